// ===== rtl/assert_macros.svh =====
// assert_macros.svh: concurrent assertion macros for the WAV header parser.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while in reset
`define WHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while in reset
`define WHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/whp_pkg.sv =====
// whp_pkg: types and constants shared by the WAV header parser modules.
// No dependencies.
package whp_pkg;

  localparam int WORD_W = 32;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_RIFF   = 3'd1;
  localparam logic [2:0] ST_EOF        = 3'd2;
  localparam logic [2:0] ST_FMT_SMALL  = 3'd3;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd4;
  localparam logic [2:0] ST_BAD_PARAMS = 3'd5;
  localparam logic [2:0] ST_NO_FRAMES  = 3'd6;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RIFF,
    PH_FMT_HDR,
    PH_FMT_SKIP,
    PH_FMT_BODY,
    PH_FMT_EXTRA,
    PH_DATA_HDR,
    PH_DATA_SKIP,
    PH_DIVIDE
  } phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/whp_divider.sv =====
// whp_divider: restoring divider, one quotient bit per cycle.
// Depends on whp_pkg (WORD_W, div_stat_t).
module whp_divider import whp_pkg::*; #(
  parameter int DIVISOR_W = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0] divisor,   // held stable by the caller while busy
  output div_stat_t            stat,
  output logic [WORD_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(WORD_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0]    quo_r, quo_nxt;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  assign trial = {rem_r, quo_r[WORD_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // shift in the next dividend bit, keep the subtraction when it fits
      rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// ===== rtl/wav_header_parser.sv =====
// wav_header_parser: streaming RIFF/WAVE header parser, one file byte per item.
// Depends on whp_pkg, whp_divider and assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | data_byte, first_byte, end_of_file
//   out_    | output    | out_valid / out_ready | status, format, counts, offset
//
// The last byte of a data chunk header starts the divider (frame count),
// and in_ready stays low until the divider is done and its quotient is
// loaded into the result register.
// A byte is taken while a result waits, provided out_ready frees the register.
// Reset is synchronous, active low, and leaves the parser idle.
`include "assert_macros.svh"

module wav_header_parser import whp_pkg::*; #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_is_float,
  output logic [3:0]  out_channel_count,
  output logic [31:0] out_rate_hz,
  output logic [5:0]  out_sample_bits,
  output logic [5:0]  out_frame_bytes,
  output logic [31:0] out_frame_count,
  output logic [31:0] out_samples_offset
);

  localparam int CH_W = $clog2(MAX_CHANNELS + 1);
  localparam int FB_W = $clog2(4 * MAX_CHANNELS + 1);

  phase_t      phase_r, phase_nxt;
  logic [31:0] byte_position_r, byte_position_nxt;
  logic [31:0] field_shift_r, field_shift_nxt;
  logic [4:0]  field_index_r, field_index_nxt;
  logic [31:0] skip_remaining_r, skip_remaining_nxt;
  logic [31:0] chunk_tag_r, chunk_tag_nxt;
  logic [31:0] chunk_length_r, chunk_length_nxt;
  logic [15:0] format_code_r, format_code_nxt;
  logic [15:0] channels_r, channels_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic        out_is_float_r, out_is_float_nxt;
  logic [3:0]  out_channel_count_r, out_channel_count_nxt;
  logic [31:0] out_rate_hz_r, out_rate_hz_nxt;
  logic [5:0]  out_sample_bits_r, out_sample_bits_nxt;
  logic [5:0]  out_frame_bytes_r, out_frame_bytes_nxt;
  logic [31:0] out_frame_count_r, out_frame_count_nxt;
  logic [31:0] out_samples_offset_r, out_samples_offset_nxt;

  logic        in_fire, step;
  phase_t      cur_ph, ph_step;
  logic [4:0]  idx;
  logic [31:0] pos;
  logic [31:0] shift_new;
  logic        riff_last, hdr_last, body_last, in_field;
  logic [31:0] extra_len, skip_left;
  logic [2:0]  fmt_status;
  logic        dec_err;
  logic [2:0]  dec_code;
  logic        err_fire, go_div;
  logic [2:0]  err_code;

  logic [FB_W-1:0]   frame_bytes;
  div_stat_t         div_stat;
  logic [WORD_W-1:0] quotient;

  function automatic logic [2:0] check_format(input logic [15:0] fmt,
                                              input logic [15:0] ch,
                                              input logic [31:0] rate,
                                              input logic [15:0] bits);
    logic pcm, flt, bits_ok;
    pcm = fmt == FMT_PCM;
    flt = fmt == FMT_FLOAT;
    if (pcm) begin
      bits_ok = bits == 16'd8 || bits == 16'd16 || bits == 16'd24 || bits == 16'd32;
    end else begin
      bits_ok = bits == 16'd32;
    end
    if (!pcm && !flt) begin
      return ST_BAD_FORMAT;
    end else if (rate == '0 || ch == '0 || ch > 16'(MAX_CHANNELS) || !bits_ok) begin
      return ST_BAD_PARAMS;
    end
    return ST_OK;
  endfunction

  assign in_ready = (phase_r != PH_DIVIDE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // step decode: where this byte leaves the parser, before end of file
  always_comb begin
    cur_ph    = in_first_byte ? PH_RIFF : phase_r;
    step      = in_fire && (cur_ph != PH_IDLE);
    idx       = in_first_byte ? '0 : field_index_r;
    pos       = in_first_byte ? '0 : byte_position_r;
    shift_new = {in_data_byte, in_first_byte ? 24'd0 : field_shift_r[31:8]};
    riff_last = idx >= 5'd11;
    hdr_last  = idx >= 5'd7;
    body_last = idx >= 5'd15;
    extra_len = chunk_length_r - FMT_BODY_LEN;
    skip_left = skip_remaining_r - 32'd1;
    fmt_status = check_format(format_code_r, channels_r, rate_r, shift_new[31:16]);
    dec_err  = 1'b0;
    dec_code = ST_OK;
    ph_step  = cur_ph;
    in_field = 1'b0;
    unique case (cur_ph)
      PH_RIFF: begin
        in_field = !riff_last;
        if (riff_last) begin
          if (chunk_tag_r != TAG_RIFF || shift_new != TAG_WAVE) begin
            dec_err  = 1'b1;
            dec_code = ST_BAD_RIFF;
            ph_step  = PH_IDLE;
          end else begin
            ph_step = PH_FMT_HDR;
          end
        end
      end
      PH_FMT_HDR: begin
        in_field = !hdr_last;
        if (hdr_last) begin
          if (chunk_tag_r == TAG_FMT) begin
            if (shift_new < FMT_BODY_LEN) begin
              dec_err  = 1'b1;
              dec_code = ST_FMT_SMALL;
              ph_step  = PH_IDLE;
            end else begin
              ph_step = PH_FMT_BODY;
            end
          end else if (shift_new != '0) begin
            ph_step = PH_FMT_SKIP;
          end
        end
      end
      PH_DATA_HDR: begin
        in_field = !hdr_last;
        if (hdr_last) begin
          if (chunk_tag_r == TAG_DATA) begin
            ph_step = PH_DIVIDE;
          end else if (shift_new != '0) begin
            ph_step = PH_DATA_SKIP;
          end
        end
      end
      PH_FMT_BODY: begin
        in_field = !body_last;
        if (body_last) begin
          if (fmt_status != ST_OK) begin
            dec_err  = 1'b1;
            dec_code = fmt_status;
            ph_step  = PH_IDLE;
          end else if (extra_len != '0) begin
            ph_step = PH_FMT_EXTRA;
          end else begin
            ph_step = PH_DATA_HDR;
          end
        end
      end
      PH_FMT_SKIP, PH_FMT_EXTRA, PH_DATA_SKIP: begin
        if (skip_left == '0) begin
          ph_step = (cur_ph == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
        end
      end
      PH_IDLE, PH_DIVIDE: begin
        ph_step = cur_ph;
      end
      default: begin
        ph_step = PH_IDLE;
      end
    endcase
    go_div   = step && (ph_step == PH_DIVIDE);
    // a decided error wins over end of file; a finished header wins over both
    err_fire = step && (dec_err || (in_end_of_file && ph_step != PH_DIVIDE));
    err_code = dec_err ? dec_code : ((ph_step == PH_RIFF) ? ST_BAD_RIFF : ST_EOF);
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (div_stat.done) begin
      phase_nxt = PH_IDLE;
    end else if (err_fire) begin
      phase_nxt = PH_IDLE;
    end else if (step) begin
      phase_nxt = ph_step;
    end
  end

  // field capture and byte counters
  always_comb begin
    byte_position_nxt  = byte_position_r;
    field_shift_nxt    = field_shift_r;
    field_index_nxt    = field_index_r;
    skip_remaining_nxt = skip_remaining_r;
    chunk_tag_nxt      = chunk_tag_r;
    chunk_length_nxt   = chunk_length_r;
    format_code_nxt    = format_code_r;
    channels_nxt       = channels_r;
    rate_nxt           = rate_r;
    bits_nxt           = bits_r;
    if (step) begin
      byte_position_nxt = pos + 32'd1;
      field_shift_nxt   = shift_new;
      field_index_nxt   = in_field ? idx + 5'd1 : 5'd0;
      case (cur_ph)
        PH_RIFF: begin
          if (idx == 5'd3) begin
            chunk_tag_nxt = shift_new;
          end
        end
        PH_FMT_HDR, PH_DATA_HDR: begin
          if (idx == 5'd3) begin
            chunk_tag_nxt = shift_new;
          end
          if (hdr_last) begin
            chunk_length_nxt   = shift_new;
            skip_remaining_nxt = shift_new;
          end
        end
        PH_FMT_BODY: begin
          if (idx == 5'd1) begin
            format_code_nxt = shift_new[31:16];
          end else if (idx == 5'd3) begin
            channels_nxt = shift_new[31:16];
          end else if (idx == 5'd7) begin
            rate_nxt = shift_new;
          end
          if (body_last) begin
            bits_nxt           = shift_new[31:16];
            skip_remaining_nxt = extra_len;
          end
        end
        PH_FMT_SKIP, PH_FMT_EXTRA, PH_DATA_SKIP: begin
          skip_remaining_nxt = skip_left;
        end
        default: begin
        end
      endcase
    end
  end

  // divisor: bits are 8..32 and channels within range once the format passed
  assign frame_bytes = FB_W'(bits_r[5:3]) * FB_W'(channels_r[CH_W-1:0]);

  // the data size arrives on the starting byte itself
  whp_divider #(
    .DIVISOR_W(FB_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_div),
    .dividend (chunk_length_nxt),
    .divisor  (frame_bytes),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // result register
  always_comb begin
    out_valid_nxt          = out_valid_r && !out_ready;
    out_status_nxt         = out_status_r;
    out_is_float_nxt       = out_is_float_r;
    out_channel_count_nxt  = out_channel_count_r;
    out_rate_hz_nxt        = out_rate_hz_r;
    out_sample_bits_nxt    = out_sample_bits_r;
    out_frame_bytes_nxt    = out_frame_bytes_r;
    out_frame_count_nxt    = out_frame_count_r;
    out_samples_offset_nxt = out_samples_offset_r;
    if (err_fire || (div_stat.done && quotient == '0)) begin
      out_valid_nxt          = 1'b1;
      out_status_nxt         = err_fire ? err_code : ST_NO_FRAMES;
      out_is_float_nxt       = 1'b0;
      out_channel_count_nxt  = '0;
      out_rate_hz_nxt        = '0;
      out_sample_bits_nxt    = '0;
      out_frame_bytes_nxt    = '0;
      out_frame_count_nxt    = '0;
      out_samples_offset_nxt = '0;
    end else if (div_stat.done) begin
      out_valid_nxt          = 1'b1;
      out_status_nxt         = ST_OK;
      out_is_float_nxt       = format_code_r == FMT_FLOAT;
      out_channel_count_nxt  = channels_r[3:0];
      out_rate_hz_nxt        = rate_r;
      out_sample_bits_nxt    = bits_r[5:0];
      out_frame_bytes_nxt    = 6'(frame_bytes);
      out_frame_count_nxt    = quotient;
      out_samples_offset_nxt = byte_position_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      byte_position_r  <= '0;
      field_shift_r    <= '0;
      field_index_r    <= '0;
      skip_remaining_r <= '0;
      chunk_tag_r      <= '0;
      chunk_length_r   <= '0;
      format_code_r    <= '0;
      channels_r       <= '0;
      rate_r           <= '0;
      bits_r           <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      byte_position_r  <= byte_position_nxt;
      field_shift_r    <= field_shift_nxt;
      field_index_r    <= field_index_nxt;
      skip_remaining_r <= skip_remaining_nxt;
      chunk_tag_r      <= chunk_tag_nxt;
      chunk_length_r   <= chunk_length_nxt;
      format_code_r    <= format_code_nxt;
      channels_r       <= channels_nxt;
      rate_r           <= rate_nxt;
      bits_r           <= bits_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    out_status_r         <= out_status_nxt;
    out_is_float_r       <= out_is_float_nxt;
    out_channel_count_r  <= out_channel_count_nxt;
    out_rate_hz_r        <= out_rate_hz_nxt;
    out_sample_bits_r    <= out_sample_bits_nxt;
    out_frame_bytes_r    <= out_frame_bytes_nxt;
    out_frame_count_r    <= out_frame_count_nxt;
    out_samples_offset_r <= out_samples_offset_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_is_float       = out_is_float_r;
  assign out_channel_count  = out_channel_count_r;
  assign out_rate_hz        = out_rate_hz_r;
  assign out_sample_bits    = out_sample_bits_r;
  assign out_frame_bytes    = out_frame_bytes_r;
  assign out_frame_count    = out_frame_count_r;
  assign out_samples_offset = out_samples_offset_r;

  `WHP_ASSERT_NOW(a_done_in_divide, div_stat.done, phase_r == PH_DIVIDE, "divider done outside divide phase")
  `WHP_ASSERT_NEXT(a_start_busy, go_div, div_stat.busy && phase_r == PH_DIVIDE, "divider not started")
  `WHP_ASSERT_NOW(a_hold_in_divide, phase_r == PH_DIVIDE, !in_ready, "byte taken during divide")
  `WHP_ASSERT_NOW(a_err_zero, out_valid_r && out_status_r != ST_OK, out_channel_count_r == '0 && out_frame_count_r == '0 && out_samples_offset_r == '0, "error result carries fields")

endmodule

// ===== bench/wav_header_parser_test.sv =====
// wav_header_parser_test: self-checking bench for the streaming WAV header parser.
// Depends on whp_pkg and the wav_header_parser RTL. Random stimulus and random
// handshake gaps on both sides, with a behavioral parser predicting each report.
module wav_header_parser_test import whp_pkg::*; ();

  localparam int MAX_CHANS = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef logic [7:0] octet_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_float;
    logic [3:0]  channels;
    logic [31:0] rate;
    logic [5:0]  bits;
    logic [5:0]  frame_bytes;
    logic [31:0] frames;
    logic [31:0] offset;
  } wav_report_t;

  typedef struct packed {
    octet_t     b;
    logic       first;
    logic       eof;
    logic       typed;
    logic [2:0] st;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_first_byte = 1'b0;
  logic        in_end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic        out_is_float;
  logic [3:0]  out_channel_count;
  logic [31:0] out_rate_hz;
  logic [5:0]  out_sample_bits;
  logic [5:0]  out_frame_bytes;
  logic [31:0] out_frame_count;
  logic [31:0] out_samples_offset;

  wav_report_t expected_reports[$];
  octet_t      file_image[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;

  // parser state mirrored by the predictor
  phase_t      prs_phase = PH_IDLE;
  logic [31:0] prs_pos = '0;
  logic [31:0] prs_shift = '0;
  logic [4:0]  prs_idx = '0;
  logic [31:0] prs_skip = '0;
  logic [31:0] prs_tag = '0;
  logic [31:0] prs_len = '0;
  logic [15:0] prs_fmt = '0;
  logic [15:0] prs_chans = '0;
  logic [31:0] prs_rate = '0;
  logic [15:0] prs_bits = '0;

  wav_header_parser #(.MAX_CHANNELS(MAX_CHANS)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_end_of_file     (in_end_of_file),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_is_float       (out_is_float),
    .out_channel_count  (out_channel_count),
    .out_rate_hz        (out_rate_hz),
    .out_sample_bits    (out_sample_bits),
    .out_frame_bytes    (out_frame_bytes),
    .out_frame_count    (out_frame_count),
    .out_samples_offset (out_samples_offset)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_image.push_back(v[8*i +: 8]);
  endfunction

  function automatic bit abort_file(output wav_report_t rep, input logic [2:0] st);
    rep = '0;
    rep.status = st;
    prs_phase = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic void skip_to(input logic [31:0] len, input phase_t skip_ph,
                                  input phase_t next_ph);
    prs_idx = '0;
    if (len == 0) begin
      prs_phase = next_ph;
    end else begin
      prs_skip = len;
      prs_phase = skip_ph;
    end
  endfunction

  // Advance the parser by one file byte; returns 1 when the byte ends the file's report.
  function automatic bit parse_byte(input octet_t b, input bit first, input bit eof,
                                    output wav_report_t rep);
    logic [31:0] pos;
    logic [4:0]  idx;
    logic [31:0] fbytes;
    logic [31:0] frames;
    logic        bits_ok;
    rep = '0;
    if (first) begin
      prs_pos = '0; prs_shift = '0; prs_idx = '0; prs_skip = '0; prs_tag = '0;
      prs_len = '0; prs_fmt = '0; prs_chans = '0; prs_rate = '0; prs_bits = '0;
      prs_phase = PH_RIFF;
    end
    if (prs_phase == PH_IDLE) return 1'b0;
    pos = prs_pos;
    prs_pos = pos + 1;
    prs_shift = {b, prs_shift[31:8]};
    idx = prs_idx;
    case (prs_phase)
      PH_RIFF: begin
        if (idx == 3) prs_tag = prs_shift;
        if (idx >= 11) begin
          if (prs_tag != TAG_RIFF || prs_shift != TAG_WAVE) return abort_file(rep, ST_BAD_RIFF);
          prs_idx = '0;
          prs_phase = PH_FMT_HDR;
        end else begin
          prs_idx = idx + 1;
        end
      end
      PH_FMT_HDR, PH_DATA_HDR: begin
        if (idx == 3) prs_tag = prs_shift;
        if (idx >= 7) begin
          prs_len = prs_shift;
          prs_idx = '0;
          if (prs_phase == PH_FMT_HDR) begin
            if (prs_tag == TAG_FMT) begin
              if (prs_len < FMT_BODY_LEN) return abort_file(rep, ST_FMT_SMALL);
              prs_phase = PH_FMT_BODY;
            end else begin
              skip_to(prs_len, PH_FMT_SKIP, PH_FMT_HDR);
            end
          end else if (prs_tag == TAG_DATA) begin
            fbytes = (32'(prs_bits) / 8) * 32'(prs_chans);
            frames = (fbytes != 0) ? prs_len / fbytes : '0;
            if (frames == 0) return abort_file(rep, ST_NO_FRAMES);
            rep.status = ST_OK;
            rep.is_float = (prs_fmt == FMT_FLOAT);
            rep.channels = prs_chans[3:0];
            rep.rate = prs_rate;
            rep.bits = prs_bits[5:0];
            rep.frame_bytes = fbytes[5:0];
            rep.frames = frames;
            rep.offset = pos + 1;
            prs_phase = PH_IDLE;
            return 1'b1;
          end else begin
            skip_to(prs_len, PH_DATA_SKIP, PH_DATA_HDR);
          end
        end else begin
          prs_idx = idx + 1;
        end
      end
      PH_FMT_BODY: begin
        if (idx == 1) prs_fmt = prs_shift[31:16];
        else if (idx == 3) prs_chans = prs_shift[31:16];
        else if (idx == 7) prs_rate = prs_shift;
        if (idx >= 15) begin
          prs_bits = prs_shift[31:16];
          // validate before any extra fmt bytes are skipped
          if (prs_fmt != FMT_PCM && prs_fmt != FMT_FLOAT) return abort_file(rep, ST_BAD_FORMAT);
          if (prs_fmt == FMT_PCM)
            bits_ok = (prs_bits == 8 || prs_bits == 16 || prs_bits == 24 || prs_bits == 32);
          else
            bits_ok = (prs_bits == 32);
          if (prs_rate == 0 || prs_chans == 0 || prs_chans > MAX_CHANS || !bits_ok)
            return abort_file(rep, ST_BAD_PARAMS);
          skip_to(prs_len - FMT_BODY_LEN, PH_FMT_EXTRA, PH_DATA_HDR);
        end else begin
          prs_idx = idx + 1;
        end
      end
      default: begin
        prs_skip = prs_skip - 1;
        if (prs_skip == 0) begin
          prs_idx = '0;
          prs_phase = (prs_phase == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
        end
      end
    endcase
    if (eof) return abort_file(rep, (prs_phase == PH_RIFF) ? ST_BAD_RIFF : ST_EOF);
    return 1'b0;
  endfunction

  // Offer one byte after a random gap (none when fast) and hold it until taken.
  // A typed status replaces the predicted report.
  task automatic send_item(input octet_t b, input bit first, input bit eof,
                           input bit typed, input logic [2:0] st, input bit fast);
    int gap;
    wav_report_t rep;
    bit has_rep;
    gap = fast ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_first_byte <= first;
    in_end_of_file <= eof;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    has_rep = parse_byte(b, first, eof, rep);
    if (typed) begin
      rep = '0;
      rep.status = st;
      has_rep = 1'b1;
    end
    if (has_rep) begin
      expected_reports.push_back(rep);
    end
  endtask

  task automatic note_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // receiving side: random holds, plus one long hold to back up the parser
  initial begin : drain
    int hold;
    int taken;
    wav_report_t want;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected report, expected none, actual status %0d",
                 $time, out_status);
      end else begin
        want = expected_reports.pop_front();
        note_field("status", want.status, out_status);
        note_field("is_float", want.is_float, out_is_float);
        note_field("channel_count", want.channels, out_channel_count);
        note_field("rate_hz", want.rate, out_rate_hz);
        note_field("sample_bits", want.bits, out_sample_bits);
        note_field("frame_bytes", want.frame_bytes, out_frame_bytes);
        note_field("frame_count", want.frames, out_frame_count);
        note_field("samples_offset", want.offset, out_samples_offset);
      end
      taken++;
      if (taken == 6) begin
        out_ready <= 1'b0;
        repeat (800) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    static stim_row_t opening_rows [19] = '{
      '{8'h5A, 1'b0, 1'b0, 1'b0, ST_OK},          // ignored while idle after reset
      '{8'hFF, 1'b1, 1'b1, 1'b1, ST_BAD_RIFF},    // one-byte file
      '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},          // ignored after a report
      '{8'h52, 1'b1, 1'b0, 1'b0, ST_OK},
      '{8'h49, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h52, 1'b1, 1'b0, 1'b0, ST_OK},          // restart mid-header
      '{8'h49, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h46, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h46, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h57, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h41, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h56, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h45, 1'b0, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b1, 1'b1, ST_EOF},         // file ends inside the chunk scan
      '{8'h80, 1'b1, 1'b1, 1'b1, ST_BAD_RIFF}     // start and end on the same byte
    };
    int pick;
    int n;
    int k;
    int last;
    int eof_at;
    bit fast;
    logic [31:0] tag;
    logic [31:0] clen;
    logic [15:0] fcode;
    logic [15:0] chans;
    logic [15:0] bits;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      send_item(opening_rows[i].b, opening_rows[i].first, opening_rows[i].eof,
                opening_rows[i].typed, opening_rows[i].st, 1'b0);

    while (items_sent < 1450) begin
      fast = ($urandom_range(0, 3) == 0);
      file_image.delete();
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // noise: random bytes with random start and end marks
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
          send_item(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                    1'b0, ST_OK, fast);
        continue;
      end

      put_le(TAG_RIFF, 4);
      put_le($urandom, 4);
      put_le(TAG_WAVE, 4);
      if ($urandom_range(0, 19) == 0) begin
        k = $urandom_range(0, 11);
        file_image[k] = file_image[k] ^ 8'($urandom_range(1, 255));
      end

      // other chunks ahead of fmt, sometimes one tagged data
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) begin
        tag = ($urandom_range(0, 3) == 0) ? TAG_DATA : $urandom;
        if (tag == TAG_FMT) tag = tag ^ 32'h1;
        clen = $urandom_range(0, 7);
        put_le(tag, 4);
        put_le(clen, 4);
        repeat (clen) put_le($urandom, 1);
      end

      pick = $urandom_range(0, 99);
      clen = (pick < 85) ? 16 : (pick < 93) ? $urandom_range(17, 21) : $urandom_range(0, 15);
      put_le(TAG_FMT, 4);
      put_le(clen, 4);
      pick = $urandom_range(0, 99);
      fcode = (pick < 45) ? FMT_PCM : (pick < 90) ? FMT_FLOAT : 16'($urandom);
      pick = $urandom_range(0, 99);
      chans = (pick < 90) ? 16'($urandom_range(1, MAX_CHANS)) :
              (pick < 94) ? 16'd0 : (pick < 97) ? 16'(MAX_CHANS + 1) : 16'($urandom);
      if ($urandom_range(0, 9) == 0)
        bits = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
      else if (fcode == FMT_FLOAT)
        bits = 16'd32;
      else
        bits = 16'(8 * $urandom_range(1, 4));
      put_le(fcode, 2);
      put_le(chans, 2);
      put_le(($urandom_range(0, 19) == 0) ? 32'h0 : $urandom, 4);
      put_le($urandom, 4);
      put_le($urandom, 2);
      put_le(bits, 2);
      if (clen > 16) repeat (clen - 16) put_le($urandom, 1);

      // other chunks ahead of data, sometimes a second fmt
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) begin
        tag = ($urandom_range(0, 3) == 0) ? TAG_FMT : $urandom;
        if (tag == TAG_DATA) tag = tag ^ 32'h1;
        clen = $urandom_range(0, 7);
        put_le(tag, 4);
        put_le(clen, 4);
        repeat (clen) put_le($urandom, 1);
      end

      pick = $urandom_range(0, 99);
      put_le(TAG_DATA, 4);
      put_le((pick < 40) ? 32'($urandom_range(0, 64)) : (pick < 80) ? $urandom :
             (pick < 90) ? 32'hFFFF_FFFF : 32'h0, 4);
      repeat ($urandom_range(0, 3)) put_le($urandom, 1);

      // cut the file short, or mark its last byte, now and then
      pick = $urandom_range(0, 99);
      last = file_image.size() - 1;
      eof_at = -1;
      if (pick < 15) begin
        last = $urandom_range(0, last);
        eof_at = last;
      end else if (pick < 30) begin
        eof_at = last;
      end
      for (int i = 0; i <= last; i++)
        send_item(file_image[i], i == 0, i == eof_at, 1'b0, ST_OK, fast);
    end

    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
